>>> hw/rtl/rfre_pkg.sv
package rfre_pkg;

    localparam int MAX_SCREEN_DIM = 4096;
    localparam int COORD_BITS     = 16;
    localparam int PIX_BITS       = $clog2(MAX_SCREEN_DIM);
    localparam int WIDE_BITS      = COORD_BITS + 4;
    localparam int OFFSET_BITS    = 25;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [31:0] INVERT_MASK = 32'h00FF_FFFF;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_XOR   = 2'd2
    } op_kind_t;

    typedef enum logic [1:0] {
        MODE_SOLID   = 2'd0,
        MODE_CHECKER = 2'd1,
        MODE_OUTLINE = 2'd2,
        MODE_INVERT  = 2'd3
    } draw_mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CLIP_LEFT     = 3'd0,
        CFG_CLIP_TOP      = 3'd1,
        CFG_CLIP_WIDTH    = 3'd2,
        CFG_CLIP_HEIGHT   = 3'd3,
        CFG_SCREEN_WIDTH  = 3'd4,
        CFG_SCREEN_HEIGHT = 3'd5,
        CFG_ROW_PITCH     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] clip_left;
        logic signed [COORD_BITS-1:0] clip_top;
        logic signed [COORD_BITS-1:0] clip_width;
        logic signed [COORD_BITS-1:0] clip_height;
        logic [12:0]                  screen_width;
        logic [12:0]                  screen_height;
        logic [13:0]                  row_pitch;
    } cfg_t;

    typedef struct packed {
        logic                         is_load;
        logic [1:0]                   mode;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] w;
        logic signed [COORD_BITS-1:0] h;
        logic [31:0]                  color_a;
        logic [31:0]                  color_b;
    } item_t;

    typedef struct packed {
        logic                ok;
        logic [PIX_BITS-1:0] x0;
        logic [PIX_BITS-1:0] x1;
        logic [PIX_BITS-1:0] y0;
        logic [PIX_BITS-1:0] y1;
    } seg_t;

    function automatic logic signed [WIDE_BITS-1:0] wext(logic signed [COORD_BITS-1:0] v);
        return {{(WIDE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] dimv(logic [12:0] v);
        logic [12:0] d;
        d = (v > 13'(MAX_SCREEN_DIM)) ? 13'(MAX_SCREEN_DIM) : v;
        return {{(WIDE_BITS-13){1'b0}}, d};
    endfunction

    // Clipped bounds of one segment of a command.
    function automatic seg_t seg_setup(logic [1:0] mode, logic [1:0] k, item_t c, cfg_t g);
        logic signed [WIDE_BITS-1:0] rx, ry, rw, rh, lx, ly, hx, hy, cl, ct, t;
        logic [1:0] e;
        seg_t s;
        rx = wext(c.x);
        ry = wext(c.y);
        rw = wext(c.w);
        rh = wext(c.h);
        e = (mode == MODE_OUTLINE) ? k : 2'(k + 2'd2);
        if (mode == MODE_OUTLINE || mode == MODE_INVERT) begin
            case (e)
                2'd0: rh = WIDE_BITS'(1);
                2'd1: begin ry = ry + rh - WIDE_BITS'(1); rh = WIDE_BITS'(1); end
                2'd2: rw = WIDE_BITS'(1);
                default: begin rx = rx + rw - WIDE_BITS'(1); rw = WIDE_BITS'(1); end
            endcase
        end
        lx = (rx > 0) ? rx : '0;
        ly = (ry > 0) ? ry : '0;
        hx = rx + rw;
        if (hx > dimv(g.screen_width)) hx = dimv(g.screen_width);
        hy = ry + rh;
        if (hy > dimv(g.screen_height)) hy = dimv(g.screen_height);
        if (mode != MODE_INVERT) begin
            cl = wext(g.clip_left);
            ct = wext(g.clip_top);
            if (cl > lx) lx = cl;
            if (ct > ly) ly = ct;
            t = cl + wext(g.clip_width);
            if (t < hx) hx = t;
            t = ct + wext(g.clip_height);
            if (t < hy) hy = t;
        end
        s.ok = (rw > 0) && (rh > 0) && (hx > lx) && (hy > ly);
        s.x0 = lx[PIX_BITS-1:0];
        t = hx - WIDE_BITS'(1);
        s.x1 = t[PIX_BITS-1:0];
        s.y0 = ly[PIX_BITS-1:0];
        t = hy - WIDE_BITS'(1);
        s.y1 = t[PIX_BITS-1:0];
        return s;
    endfunction

endpackage

>>> hw/rtl/rfre_front.sv
module rfre_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [1:0]                   s_draw_mode,
    input  logic signed [15:0]           s_rect_x,
    input  logic signed [15:0]           s_rect_y,
    input  logic signed [15:0]           s_rect_w,
    input  logic signed [15:0]           s_rect_h,
    input  logic [31:0]                  s_color_a,
    input  logic [31:0]                  s_color_b,
    output logic                         q_valid,
    output rfre_pkg::item_t              q_item,
    input  logic                         q_pop
);
    import rfre_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    item_t      in_item;

    always_comb begin
        in_item.is_load = (s_req_type == 1'b0);
        in_item.mode    = s_draw_mode;
        in_item.x       = s_rect_x;
        in_item.y       = s_rect_y;
        in_item.w       = s_rect_w;
        in_item.h       = s_rect_h;
        in_item.color_a = s_color_a;
        in_item.color_b = s_color_b;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

>>> hw/rtl/rfre_back.sv
module rfre_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rfre_pkg::cfg_t         cfg,
    input  logic                   q_valid,
    input  rfre_pkg::item_t        q_item,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_op_kind,
    output logic [11:0]            m_pixel_x,
    output logic [11:0]            m_pixel_y,
    output logic [24:0]            m_word_offset,
    output logic [31:0]            m_pixel_color,
    output logic                   m_done_res
);
    import rfre_pkg::*;

    item_t               cmd_reg;
    logic                active_reg, active_next;
    logic [1:0]          edge_reg, edge_next;
    logic [PIX_BITS-1:0] x0_reg, x1_reg, y0_reg, y1_reg, cx_reg, cy_reg;
    logic [PIX_BITS-1:0] x0_next, x1_next, y0_next, y1_next, cx_next, cy_next;
    logic                out_valid_reg;
    op_kind_t            op_next;
    logic [31:0]         color_next;
    logic                done_next;
    logic [PIX_BITS-1:0] px_next, py_next;
    logic [OFFSET_BITS-1:0] ofs_full;
    item_t               src;
    seg_t                segs [4];
    logic [2:0]          start;
    logic                found, want_seek, empty_outline;
    logic [1:0]          found_k;
    logic [31:0]         ch_color;

    assign q_pop = q_valid && (!out_valid_reg || m_ready);
    assign src   = q_item.is_load ? q_item : cmd_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            segs[k] = seg_setup(src.mode, 2'(k), src, cfg);
        end
    end

    always_comb begin
        empty_outline = (src.mode == MODE_OUTLINE || src.mode == MODE_INVERT)
                        && (src.w <= 0 || src.h <= 0);
        start = q_item.is_load ? 3'd0 : 3'(edge_reg) + 3'd1;
        found = 1'b0;
        found_k = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (!found && 3'(k) >= start && !empty_outline && segs[k].ok
                && (k == 0 || src.mode == MODE_OUTLINE || src.mode == MODE_INVERT)) begin
                found = 1'b1;
                found_k = 2'(k);
            end
        end
    end

    always_comb begin
        active_next = active_reg;
        edge_next = edge_reg;
        x0_next = x0_reg; x1_next = x1_reg; y0_next = y0_reg; y1_next = y1_reg;
        cx_next = cx_reg; cy_next = cy_reg;
        op_next = OP_NONE;
        color_next = '0;
        done_next = 1'b0;
        px_next = '0;
        py_next = '0;
        want_seek = 1'b0;
        ch_color = (cmd_reg.mode == MODE_CHECKER && (cx_reg[0] ^ cy_reg[0]))
                   ? cmd_reg.color_b : cmd_reg.color_a;
        if (q_item.is_load) begin
            want_seek = 1'b1;
        end else if (!active_reg) begin
            done_next = 1'b1;
        end else begin
            px_next = cx_reg;
            py_next = cy_reg;
            if (cmd_reg.mode == MODE_INVERT) begin
                op_next = OP_XOR;
            end else if (cmd_reg.mode != MODE_CHECKER || ch_color != 32'd0) begin
                op_next = OP_WRITE;
                color_next = ch_color;
            end
            if (cx_reg < x1_reg) begin
                cx_next = cx_reg + 1'b1;
            end else if (cy_reg < y1_reg) begin
                cx_next = x0_reg;
                cy_next = cy_reg + 1'b1;
            end else begin
                want_seek = 1'b1;
            end
        end
        if (want_seek) begin
            active_next = found;
            done_next = !found;
            if (found) begin
                edge_next = found_k;
                x0_next = segs[found_k].x0;
                x1_next = segs[found_k].x1;
                y0_next = segs[found_k].y0;
                y1_next = segs[found_k].y1;
                cx_next = segs[found_k].x0;
                cy_next = segs[found_k].y0;
            end
        end
        ofs_full = OFFSET_BITS'(py_next * cfg.row_pitch) + OFFSET_BITS'(px_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            edge_reg      <= 2'd0;
        end else begin
            if (m_ready) out_valid_reg <= 1'b0;
            if (q_pop) begin
                out_valid_reg <= 1'b1;
                active_reg    <= active_next;
                edge_reg      <= edge_next;
                if (q_item.is_load) cmd_reg <= q_item;
                x0_reg <= x0_next; x1_reg <= x1_next;
                y0_reg <= y0_next; y1_reg <= y1_next;
                cx_reg <= cx_next; cy_reg <= cy_next;
                m_op_kind     <= op_next;
                m_pixel_x     <= px_next;
                m_pixel_y     <= py_next;
                m_word_offset <= ofs_full;
                m_pixel_color <= color_next;
                m_done_res    <= done_next;
            end
        end
    end

    assign m_valid = out_valid_reg;

    a_op_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_op_kind != 2'd3)) else $error("illegal op kind");
    a_xor_no_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_op_kind == OP_XOR) |-> (m_pixel_color == 32'd0))
        else $error("xor op carries a color");
    a_cursor_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (cx_reg <= x1_reg && cy_reg <= y1_reg && x0_reg <= cx_reg))
        else $error("cursor left its span");
    a_idle_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_item.is_load && !active_reg) |=> (m_done_res && m_op_kind == OP_NONE))
        else $error("idle step not marked done");

endmodule

>>> hw/rtl/rect_fill_raster_engine.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      req_type, draw_mode, rect_*, color_a/b
// m_        out        m_valid / m_ready      op_kind, pixel_x/y, word_offset, color, done
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// One request in and one result out per cycle when neither side stalls; every
// request, load or step, passes the back end in a single pop, with its segment
// search and clip in that same cycle. A two-entry request queue parts the input
// side from the back end, and the result register parts it from the output.
// Reset (synchronous, active low) empties the queue, drops any command and
// restores the register defaults. The config port is always ready.
module rect_fill_raster_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [1:0]          s_draw_mode,
    input  logic signed [15:0]  s_rect_x,
    input  logic signed [15:0]  s_rect_y,
    input  logic signed [15:0]  s_rect_w,
    input  logic signed [15:0]  s_rect_h,
    input  logic [31:0]         s_color_a,
    input  logic [31:0]         s_color_b,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_op_kind,
    output logic [11:0]         m_pixel_x,
    output logic [11:0]         m_pixel_y,
    output logic [24:0]         m_word_offset,
    output logic [31:0]         m_pixel_color,
    output logic                m_done_res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import rfre_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid, q_pop;
    item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip_left     <= '0;
            cfg_reg.clip_top      <= '0;
            cfg_reg.clip_width    <= 16'sd4096;
            cfg_reg.clip_height   <= 16'sd4096;
            cfg_reg.screen_width  <= 13'd4096;
            cfg_reg.screen_height <= 13'd4096;
            cfg_reg.row_pitch     <= 14'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CLIP_LEFT:     cfg_reg.clip_left     <= cfg_data;
                CFG_CLIP_TOP:      cfg_reg.clip_top      <= cfg_data;
                CFG_CLIP_WIDTH:    cfg_reg.clip_width    <= cfg_data;
                CFG_CLIP_HEIGHT:   cfg_reg.clip_height   <= cfg_data;
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[12:0];
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[12:0];
                CFG_ROW_PITCH:     cfg_reg.row_pitch     <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    rfre_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_draw_mode(s_draw_mode),
        .s_rect_x(s_rect_x), .s_rect_y(s_rect_y),
        .s_rect_w(s_rect_w), .s_rect_h(s_rect_h),
        .s_color_a(s_color_a), .s_color_b(s_color_b),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    rfre_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_op_kind(m_op_kind), .m_pixel_x(m_pixel_x), .m_pixel_y(m_pixel_y),
        .m_word_offset(m_word_offset), .m_pixel_color(m_pixel_color),
        .m_done_res(m_done_res)
    );

endmodule
